/* hdl/assert_macros.svh */
// Assertion macros shared by the vertex projection RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

/* hdl/vpv_pkg.sv */
// Types and constants of the vertex projection unit.
// Used by every module of the block; depends on nothing.
package vpv_pkg;
   localparam int NUM_REGS   = 8;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int QUEUE_DEPTH = 8;
   localparam int ROW_X = 0;
   localparam int ROW_Y = 1;
   localparam int ROW_W = 3;

   typedef logic [NUM_REGS-1:0][CSR_DATA_W-1:0] coef_bank_type;

   typedef struct packed {
      logic w_zero;
      logic saturated;
   } vpv_flags_type;
endpackage

/* hdl/vpv_front.sv */
// Front end: matrix rows for x, y and w, floor shift, saturation and numerators.
// Depends on vpv_pkg; fixed four-stage pipeline that never stalls.
module vpv_front #(
   parameter int HB     = 9,
   parameter int HALF_X = 320,
   parameter int HALF_Y = 240
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [31:0]                   pos_x,
   input  logic [31:0]                   pos_y,
   input  logic [31:0]                   pos_z,
   input  vpv_pkg::coef_bank_type        coef,
   output logic                          out_valid,
   output logic signed [32+HB:0]         prod_x,
   output logic signed [32+HB:0]         prod_y,
   output logic [31:0]                   clip_w,
   output vpv_pkg::vpv_flags_type        flags
);
   localparam logic [HB:0] HX = (HB+1)'(HALF_X);
   localparam logic [HB:0] HY = (HB+1)'(HALF_Y);

   logic [3:0] valid_ff;
   logic signed [63:0] p_ff [3][3];
   logic signed [65:0] s_ff [3];
   logic [31:0] r_ff [3];
   logic        rsat_ff;
   logic signed [32+HB:0] px_ff, py_ff;
   logic [31:0] cw_ff;
   vpv_pkg::vpv_flags_type fl_ff;
   logic [31:0] r_in [3];
   logic [2:0]  rsat;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else       valid_ff <= {valid_ff[2:0], in_valid};
   end

   for (genvar r = 0; r < 3; r++) begin : g_row
      localparam int ROW = (r == 0) ? vpv_pkg::ROW_X :
                           (r == 1) ? vpv_pkg::ROW_Y : vpv_pkg::ROW_W;
      logic signed [50:0] sh;
      logic [19:0] hi;
      always_comb begin
         sh = 51'(s_ff[r] >>> 16) + 51'($signed(coef[2*ROW+1][63:32]));
         hi = sh[50:31];
         rsat[r] = !((&hi) || !(|hi));
         r_in[r] = rsat[r] ? (sh[50] ? 32'h8000_0000 : 32'h7fff_ffff) : sh[31:0];
      end
      always_ff @(posedge clock) begin
         p_ff[r][0] <= $signed(pos_x) * $signed(coef[2*ROW][31:0]);
         p_ff[r][1] <= $signed(pos_y) * $signed(coef[2*ROW][63:32]);
         p_ff[r][2] <= $signed(pos_z) * $signed(coef[2*ROW+1][31:0]);
         s_ff[r] <= 66'(p_ff[r][0]) + 66'(p_ff[r][1]) + 66'(p_ff[r][2]);
         r_ff[r] <= r_in[r];
      end
   end

   always_ff @(posedge clock) begin
      rsat_ff <= |rsat;
      px_ff <= $signed(r_ff[0]) * $signed(HX);
      py_ff <= $signed(r_ff[1]) * $signed(HY);
      cw_ff <= r_ff[2];
      fl_ff.w_zero    <= (r_ff[2] == '0);
      fl_ff.saturated <= rsat_ff;
   end

   assign out_valid = valid_ff[3];
   assign prod_x = px_ff;
   assign prod_y = py_ff;
   assign clip_w = cw_ff;
   assign flags  = fl_ff;
endmodule

/* hdl/vpv_queue.sv */
// Short queue between front and back end with a credit count over the front pipeline.
// Depends on vpv_pkg for its depth.
module vpv_queue #(
   parameter int WIDTH = 96
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   output logic             ready,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop_enable,
   output logic             pop,
   output logic [WIDTH-1:0] pop_data
);
   localparam int DEPTH = vpv_pkg::QUEUE_DEPTH;
   localparam int PW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, rd_ff;
   logic [PW:0]   cnt_ff, credit_ff;

   assign pop      = pop_enable && (cnt_ff != '0);
   assign pop_data = mem_ff[rd_ff];
   assign ready    = credit_ff < (PW+1)'(DEPTH);

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
         credit_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff    <= cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
         credit_ff <= credit_ff + (PW+1)'(accept) - (PW+1)'(pop);
      end
   end
endmodule

/* hdl/vpv_back.sv */
// Back end: pipelined restoring division of both numerators by w, viewport offset,
// saturation and the output register. Depends on vpv_pkg.
module vpv_back #(
   parameter int HB     = 9,
   parameter int HALF_X = 320,
   parameter int HALF_Y = 240
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic signed [32+HB:0]  prod_x,
   input  logic signed [32+HB:0]  prod_y,
   input  logic [31:0]            clip_w,
   input  vpv_pkg::vpv_flags_type flags,
   output logic                   enable,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [95:0]            out_data,
   output logic [1:0]             out_user
);
   localparam int MW = 31 + HB + 16;
   localparam int SW = MW + 2;
   localparam logic [SW-1:0] OFS_X = SW'(HALF_X) << 16;
   localparam logic [SW-1:0] OFS_Y = SW'(HALF_Y) << 16;

   logic [MW-1:0] ax_ff [MW+1];
   logic [MW-1:0] ay_ff [MW+1];
   logic [31:0]   rx_ff [MW+1];
   logic [31:0]   ry_ff [MW+1];
   logic [31:0]   d_ff  [MW+1];
   logic [31:0]   cw_ff [MW+1];
   logic          nx_ff [MW+1];
   logic          ny_ff [MW+1];
   vpv_pkg::vpv_flags_type fl_ff [MW+1];
   logic [MW:0]   v_ff;

   logic          out_valid_ff;
   logic [95:0]   out_data_ff;
   logic [1:0]    out_user_ff;

   logic [32+HB:0] mx, my;
   logic [SW-1:0] sum_x, sum_y;
   logic [SW-32:0] hx, hy;
   logic          ox, oy;
   logic [31:0]   sx, sy;

   assign enable = !out_valid_ff || out_ready;

   always_comb begin
      mx = prod_x[32+HB] ? -prod_x : prod_x;
      my = prod_y[32+HB] ? -prod_y : prod_y;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ax_ff[0] <= {mx[30+HB:0], 16'b0};
         ay_ff[0] <= {my[30+HB:0], 16'b0};
         rx_ff[0] <= '0;
         ry_ff[0] <= '0;
         d_ff[0]  <= clip_w[31] ? -clip_w : clip_w;
         cw_ff[0] <= clip_w;
         nx_ff[0] <= prod_x[32+HB] ^ clip_w[31];
         ny_ff[0] <= prod_y[32+HB] ^ clip_w[31];
         fl_ff[0] <= flags;
      end
   end

   for (genvar k = 0; k < MW; k++) begin : g_step
      logic [32:0] tx, ty;
      logic gx, gy;
      always_comb begin
         tx = {rx_ff[k], ax_ff[k][MW-1]};
         ty = {ry_ff[k], ay_ff[k][MW-1]};
         gx = tx >= {1'b0, d_ff[k]};
         gy = ty >= {1'b0, d_ff[k]};
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            ax_ff[k+1] <= {ax_ff[k][MW-2:0], gx};
            ay_ff[k+1] <= {ay_ff[k][MW-2:0], gy};
            rx_ff[k+1] <= gx ? 32'(tx - {1'b0, d_ff[k]}) : tx[31:0];
            ry_ff[k+1] <= gy ? 32'(ty - {1'b0, d_ff[k]}) : ty[31:0];
            d_ff[k+1]  <= d_ff[k];
            cw_ff[k+1] <= cw_ff[k];
            nx_ff[k+1] <= nx_ff[k];
            ny_ff[k+1] <= ny_ff[k];
            fl_ff[k+1] <= fl_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset)       v_ff <= '0;
      else if (enable) v_ff <= {v_ff[MW-1:0], in_valid};
   end

   always_comb begin
      sum_x = (nx_ff[MW] ? -{2'b0, ax_ff[MW]} : {2'b0, ax_ff[MW]}) + OFS_X;
      sum_y = (ny_ff[MW] ? -{2'b0, ay_ff[MW]} : {2'b0, ay_ff[MW]}) + OFS_Y;
      hx = sum_x[SW-1:31];
      hy = sum_y[SW-1:31];
      ox = !((&hx) || !(|hx));
      oy = !((&hy) || !(|hy));
      sx = ox ? (sum_x[SW-1] ? 32'h8000_0000 : 32'h7fff_ffff) : sum_x[31:0];
      sy = oy ? (sum_y[SW-1] ? 32'h8000_0000 : 32'h7fff_ffff) : sum_y[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset)       out_valid_ff <= 1'b0;
      else if (enable) out_valid_ff <= v_ff[MW];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         if (fl_ff[MW].w_zero) begin
            out_data_ff <= '0;
            out_user_ff <= {fl_ff[MW].saturated, 1'b1};
         end else begin
            out_data_ff <= {cw_ff[MW], sy, sx};
            out_user_ff <= {fl_ff[MW].saturated || ox || oy, 1'b0};
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign out_user  = out_user_ff;
endmodule

/* hdl/vertex_project_viewport_unit.sv */
// Perspective vertex transform with viewport map. A word passes the front pipeline,
// the credit queue and the back end, whose one-bit-per-stage divider has
// 47 + ceil(log2(H+1)) stages, H the larger half screen size.
// One word is taken every cycle while the queue has credit; the credit queue of eight words decouples the stages.
// Synchronous active-high reset clears all coefficients and empties the pipeline.
// Depends on vpv_pkg, vpv_front, vpv_queue, vpv_back and assert_macros.svh.
`include "assert_macros.svh"
module vertex_project_viewport_unit #(
   parameter int SCREEN_WIDTH  = 640,
   parameter int SCREEN_HEIGHT = 480
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // pos_x, pos_y, pos_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // screen_x, screen_y, clip_w
   output logic [1:0]  rsp_tuser,   // w_zero, saturated
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [vpv_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [vpv_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [vpv_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic        csr_pready
);
   localparam int HALF_X = SCREEN_WIDTH / 2;
   localparam int HALF_Y = SCREEN_HEIGHT / 2;
   localparam int HALF_M = (HALF_X > HALF_Y) ? HALF_X : HALF_Y;
   localparam int HB = $clog2(HALF_M + 1);
   localparam int NP = 33 + HB;
   localparam int QW = 2 * NP + 34;

   vpv_pkg::coef_bank_type coef_ff;
   logic csr_write;

   logic f_valid;
   logic signed [NP-1:0] f_px, f_py, q_px, q_py;
   logic [31:0] f_cw, q_cw;
   vpv_pkg::vpv_flags_type f_fl, q_fl;
   logic [QW-1:0] q_data;
   logic q_pop, b_enable;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = coef_ff[csr_paddr[5:3]];

   always_ff @(posedge clock) begin
      if (reset)          coef_ff <= '0;
      else if (csr_write) coef_ff[csr_paddr[5:3]] <= csr_pwdata;
   end

   vpv_front #(.HB(HB), .HALF_X(HALF_X), .HALF_Y(HALF_Y)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid && req_tready),
      .pos_x(req_tdata[31:0]), .pos_y(req_tdata[63:32]), .pos_z(req_tdata[95:64]),
      .coef(coef_ff),
      .out_valid(f_valid), .prod_x(f_px), .prod_y(f_py), .clip_w(f_cw), .flags(f_fl)
   );

   vpv_queue #(.WIDTH(QW)) u_queue (
      .clock(clock), .reset(reset),
      .accept(req_tvalid && req_tready), .ready(req_tready),
      .push(f_valid), .push_data({f_px, f_py, f_cw, f_fl}),
      .pop_enable(b_enable), .pop(q_pop), .pop_data(q_data)
   );

   assign {q_px, q_py, q_cw, q_fl} = q_data;

   vpv_back #(.HB(HB), .HALF_X(HALF_X), .HALF_Y(HALF_Y)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_pop), .prod_x(q_px), .prod_y(q_py), .clip_w(q_cw), .flags(q_fl),
      .enable(b_enable),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_data(rsp_tdata), .out_user(rsp_tuser)
   );

   `ASSERT_CLK(a_wzero_clears, clock, reset, rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[63:0] == '0)
   `ASSERT_CLK(a_wzero_match, clock, reset, rsp_tvalid |-> rsp_tuser[0] == (rsp_tdata[95:64] == '0))
   `ASSERT_CLK(a_csr_readback, clock, reset, csr_write |=> (csr_paddr[5:3] == $past(csr_paddr[5:3]) -> csr_prdata == $past(csr_pwdata)))
endmodule
